### hdl/sliding_window_anagram_match_assert.svh
`ifndef SLIDING_WINDOW_ANAGRAM_MATCH_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCH_ASSERT_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define SWAM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stream check failed");

// Next-cycle implication, clocked on aclk and disabled during reset.
`define SWAM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stream check failed");

`endif

### hdl/swam_pkg.sv
package swam_pkg;

    localparam int HIST_W          = 11;
    localparam int CFG_W           = 11;
    localparam int VALUE_W         = 16;
    localparam int ACTION_W        = 2;
    localparam int POS_W           = 21;
    localparam int TC_W            = 21;
    localparam int M_TDATA_W       = 24;
    localparam int MAX_TEXT_LENGTH = 1048576;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLY_WAIT,
        ST_LEAVE_MOD,
        ST_ENTER_MOD,
        ST_PAT_MOD
    } state_t;

    // Commands to the histogram read-modify-write unit.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
        logic win_sel;
        logic dec;
    } hist_cmd_t;

endpackage

### hdl/swam_ram.sv
module swam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/swam_hist.sv
module swam_hist #(
    parameter int NUM_BINS = 100,
    localparam int BIN_W = $clog2(NUM_BINS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swam_pkg::hist_cmd_t cmd,
    input  logic [BIN_W-1:0]    rd_bin,
    output logic                all_agree
);

    import swam_pkg::*;

    localparam int AGR_W = $clog2(NUM_BINS + 1);
    localparam int ENT_W = 2 * HIST_W;

    logic [NUM_BINS-1:0] valid_reg;
    logic [BIN_W-1:0]    addr_reg;
    logic                ent_valid_reg;
    logic                fwd_reg;
    logic [ENT_W-1:0]    fwd_data_reg;
    logic [ENT_W-1:0]    ram_q;
    logic [ENT_W-1:0]    cur_entry;
    logic [ENT_W-1:0]    new_entry;
    logic [AGR_W-1:0]    agree_reg;
    logic [AGR_W-1:0]    agree_next;
    logic [HIST_W-1:0]   pat_cnt;
    logic [HIST_W-1:0]   win_cnt;
    logic [HIST_W-1:0]   tgt_cnt;
    logic [HIST_W-1:0]   tgt_new;
    logic [HIST_W-1:0]   pat_new;
    logic [HIST_W-1:0]   win_new;
    logic                eq_before;
    logic                eq_after;

    // Each entry holds the pattern count in the upper half, the window count below.
    swam_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (addr_reg),
        .wr_data (new_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_bin),
        .rd_data (ram_q)
    );

    always_comb begin
        if (fwd_reg) begin
            cur_entry = fwd_data_reg;
        end else if (ent_valid_reg) begin
            cur_entry = ram_q;
        end else begin
            cur_entry = '0;
        end
        pat_cnt = cur_entry[ENT_W-1:HIST_W];
        win_cnt = cur_entry[HIST_W-1:0];
        tgt_cnt = cmd.win_sel ? win_cnt : pat_cnt;
        if (cmd.dec) begin
            tgt_new = (tgt_cnt != '0) ? tgt_cnt - 1'b1 : tgt_cnt;
        end else begin
            tgt_new = (tgt_cnt != {HIST_W{1'b1}}) ? tgt_cnt + 1'b1 : tgt_cnt;
        end
        pat_new   = cmd.win_sel ? pat_cnt : tgt_new;
        win_new   = cmd.win_sel ? tgt_new : win_cnt;
        new_entry = {pat_new, win_new};
        eq_before = (pat_cnt == win_cnt);
        eq_after  = (pat_new == win_new);

        agree_next = agree_reg;
        if (cmd.wr_en) begin
            if (eq_before && !eq_after) begin
                agree_next = agree_reg - 1'b1;
            end else if (!eq_before && eq_after) begin
                agree_next = agree_reg + 1'b1;
            end
        end
        all_agree = (agree_next == AGR_W'(NUM_BINS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr) begin
            valid_reg <= '0;
            agree_reg <= AGR_W'(NUM_BINS);
            fwd_reg   <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
                agree_reg           <= agree_next;
            end
            if (cmd.rd_en) begin
                // A write to the entry being read lands too late for the RAM output.
                fwd_reg <= cmd.wr_en && (addr_reg == rd_bin);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            addr_reg      <= rd_bin;
            ent_valid_reg <= valid_reg[rd_bin];
            fwd_data_reg  <= new_entry;
        end
    end

endmodule

### hdl/sliding_window_anagram_match.sv
// A text item passes through the transfer, a delay line read, the leaving bin's
// read-modify-write and the entering bin's; its result is registered at that last step,
// which waits as long as an earlier result is still unread. Synchronous active-low reset
// empties both histograms at once through per-bin valid bits and sets window_length to 1.
// A pattern item with a counted value goes through a histogram read and then a write;
// clear, ignored pattern and unused items end with the transfer.
module sliding_window_anagram_match #(
    parameter int NUM_BINS   = 100,
    parameter int MAX_WINDOW = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swam_pkg::VALUE_W-1:0]   s_tdata,     // [15:0] value
    input  logic [swam_pkg::ACTION_W-1:0]  s_tuser,     // [1:0] action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swam_pkg::M_TDATA_W-1:0] m_tdata,     // [20:0] start_position
    input  logic                           cfg_wr_en,
    input  logic [swam_pkg::CFG_W-1:0]     cfg_wr_data
);

    import swam_pkg::*;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int CODE_W = $clog2(NUM_BINS + 1);
    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int WRAP_W = LEN_W + 1;
    localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W-1:0]    window_length_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [TC_W-1:0]     text_count_reg;
    logic [TC_W-1:0]     text_count_next;
    logic [CODE_W-1:0]   code_reg;
    logic                leave_reg;
    logic                m_tvalid_reg;
    logic [POS_W-1:0]    m_pos_reg;

    logic [CMP_W-1:0]    cfg_ext;
    logic [LEN_W-1:0]    eff_len;
    logic [TC_W-1:0]     len_tc;
    logic [WRAP_W-1:0]   head_ext;
    logic [WRAP_W-1:0]   len_ext;
    logic [WRAP_W-1:0]   slot_ext;
    logic [ADDR_W-1:0]   slot;
    logic                in_range;
    logic [CODE_W-1:0]   in_code;
    logic [BIN_W-1:0]    in_idx;
    logic [CODE_W-1:0]   dly_q;
    logic                leave_ok;
    logic                enter_ok;
    logic                accept;
    logic                out_free;
    logic                commit;
    logic                dly_rd;
    logic                all_agree;
    logic                match;
    logic [TC_W:0]       pos_full;
    logic [POS_W-1:0]    pos_sat;
    hist_cmd_t           hist_cmd;
    logic [BIN_W-1:0]    hist_bin;

    always_comb begin
        cfg_ext = CMP_W'(window_length_reg);
        if (window_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(cfg_ext);
        end
        len_tc = TC_W'(eff_len);

        // Slot of the value that leaves: window length entries behind the head.
        head_ext = WRAP_W'(head_reg);
        len_ext  = WRAP_W'(eff_len);
        if (head_ext >= len_ext) begin
            slot_ext = head_ext - len_ext;
        end else begin
            slot_ext = head_ext + WRAP_W'(MAX_WINDOW) - len_ext;
        end
        slot = slot_ext[ADDR_W-1:0];

        head_next = (head_reg == ADDR_W'(MAX_WINDOW - 1)) ? '0 : head_reg + 1'b1;
        text_count_next = (text_count_reg == {TC_W{1'b1}}) ? text_count_reg
                                                          : text_count_reg + 1'b1;

        in_range = (s_tdata != '0) && (s_tdata <= VALUE_W'(NUM_BINS));
        in_code  = in_range ? CODE_W'(s_tdata) : '0;
        in_idx   = BIN_W'(s_tdata - 1'b1);

        leave_ok = leave_reg && (dly_q != '0);
        enter_ok = (code_reg != '0);
        out_free = !m_tvalid_reg || m_tready;

        match    = (text_count_next >= len_tc) && all_agree;
        pos_full = {1'b0, text_count_next} - (TC_W + 1)'(eff_len) + 1'b1;
        pos_sat  = (32'(pos_full) > MAX_TEXT_LENGTH) ? POS_W'(MAX_TEXT_LENGTH)
                                                     : pos_full[POS_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_TEXT:    state_next = ST_DLY_WAIT;
                        ACT_PATTERN: state_next = in_range ? ST_PAT_MOD : ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DLY_WAIT:  state_next = ST_LEAVE_MOD;
            ST_LEAVE_MOD: state_next = ST_ENTER_MOD;
            ST_ENTER_MOD: state_next = out_free ? ST_IDLE : ST_ENTER_MOD;
            ST_PAT_MOD:   state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        accept   = 1'b0;
        dly_rd   = 1'b0;
        commit   = 1'b0;
        hist_cmd = '0;
        hist_bin = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_TEXT: dly_rd = 1'b1;
                        ACT_PATTERN: begin
                            hist_cmd.rd_en = in_range;
                            hist_bin       = in_idx;
                        end
                        ACT_CLEAR: hist_cmd.clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_DLY_WAIT: begin
                hist_cmd.rd_en = leave_ok;
                hist_bin       = BIN_W'(dly_q - 1'b1);
            end
            ST_LEAVE_MOD: begin
                hist_cmd.wr_en   = leave_ok;
                hist_cmd.win_sel = 1'b1;
                hist_cmd.dec     = 1'b1;
                hist_cmd.rd_en   = enter_ok;
                hist_bin         = BIN_W'(code_reg - 1'b1);
            end
            ST_ENTER_MOD: begin
                // The update waits here while an earlier result is still unread.
                commit           = out_free;
                hist_cmd.wr_en   = enter_ok && out_free;
                hist_cmd.win_sel = 1'b1;
            end
            ST_PAT_MOD: begin
                hist_cmd.wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    swam_hist #(
        .NUM_BINS(NUM_BINS)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (hist_cmd),
        .rd_bin    (hist_bin),
        .all_agree (all_agree)
    );

    swam_ram #(
        .WIDTH(CODE_W),
        .DEPTH(MAX_WINDOW)
    ) u_delay (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (head_reg),
        .wr_data (code_reg),
        .rd_en   (dly_rd),
        .rd_addr (slot),
        .rd_data (dly_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_length_reg <= CFG_W'(1);
            head_reg          <= '0;
            text_count_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                window_length_reg <= cfg_wr_data;
            end
            if (accept && (s_tuser == ACT_CLEAR)) begin
                head_reg       <= '0;
                text_count_reg <= '0;
            end else if (commit) begin
                head_reg       <= head_next;
                text_count_reg <= text_count_next;
            end
            if (commit && match) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dly_rd) begin
            code_reg  <= in_code;
            leave_reg <= (text_count_reg >= len_tc);
        end
        if (commit && match) begin
            m_pos_reg <= pos_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_pos_reg);

endmodule

### hdl/swam_checker.sv
`include "sliding_window_anagram_match_assert.svh"

module swam_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [swam_pkg::ACTION_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [swam_pkg::M_TDATA_W-1:0] m_tdata
);

    import swam_pkg::*;

    // A stalled result holds until its transfer.
    `SWAM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Start positions are 1-based and the padding bits stay zero.
    `SWAM_ASSERT_IMP(a_pos_range, m_tvalid, m_tdata[23:21] == 3'b000 && m_tdata[20:0] != 21'd0)

    // A text transfer occupies the block for the following cycles.
    `SWAM_ASSERT_NXT(a_text_busy, s_tvalid && s_tready && s_tuser == ACT_TEXT, !s_tready)

    // A new result only comes out of the last update step, never while idle.
    `SWAM_ASSERT_IMP(a_rise_from_work, $rose(m_tvalid), !$past(s_tready))

endmodule

bind sliding_window_anagram_match swam_checker u_checker (.*);
